>>> rtl/core/aeb_pkg.sv
// package for the blocked arithmetic encoder
// widths, controller command and status types, total and width helpers
package aeb_pkg;

    localparam int NUM_SYMBOLS = 1024;
    localparam int COUNT_BITS  = 24;
    localparam int IDX_W       = 11;
    localparam int CUM_W       = 25;
    localparam int IV_W        = 26;
    localparam int LEN_W       = 27;
    localparam int PROD_W      = 52;
    localparam int B_W         = 5;
    localparam int CNT_W       = 6;
    localparam int DIV_STEPS   = PROD_W;
    localparam int BLK_W       = 16;
    localparam int WORD_W      = 32;
    localparam int TAB_DEPTH   = NUM_SYMBOLS + 1;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK = 1'd1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_ENCODE = 1'b1;

    typedef struct packed {
        logic capture;
        logic load_wr;
        logic rd_next;
        logic lat_c0;
        logic lat_c1;
        logic mul;
        logic mul_sel;
        logic div_step;
        logic upd;
        logic ren_emit;
        logic ren_str;
        logic push_bs;
        logic push_grp;
        logic grp_one;
        logic term_shift;
        logic flush;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic           in_op;
        logic           bs_needed;
        logic           emit_c;
        logic           str_c;
        logic           end_blk;
        logic           lo_zero;
        logic           lo_top;
        logic           push_ok;
        logic           hold_v;
        logic [B_W-1:0] b;
    } t_stat;

    function automatic logic [CUM_W-1:0] f_eff(input logic [CUM_W-1:0] v);
        logic [CUM_W-1:0] t;
        t = v;
        if (v == '0) t = CUM_W'(1);
        if (v > (CUM_W'(1) << COUNT_BITS)) t = CUM_W'(1) << COUNT_BITS;
        return t;
    endfunction

    function automatic logic [B_W-1:0] f_width(input logic [CUM_W-1:0] t);
        logic [CUM_W-1:0] v;
        logic [B_W-1:0]   bl;
        v  = t - CUM_W'(1);
        bl = '0;
        for (int i = 0; i < CUM_W; i++) begin
            if (v[i]) bl = B_W'(i + 1);
        end
        return bl + B_W'(2);
    endfunction

    function automatic logic [IV_W-1:0] f_mask(input logic [B_W-1:0] b);
        return ~({IV_W{1'b1}} << b);
    endfunction

endpackage

>>> rtl/core/aeb_ctrl.sv
// controller state machine of the blocked arithmetic encoder
// sequences table reads, divisions, renormalization and termination; uses aeb_pkg
module aeb_ctrl import aeb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BS    = 4'd1;
    localparam logic [3:0] S_RD0   = 4'd2;
    localparam logic [3:0] S_RD1   = 4'd3;
    localparam logic [3:0] S_RD2   = 4'd4;
    localparam logic [3:0] S_MUL0  = 4'd5;
    localparam logic [3:0] S_DIV0  = 4'd6;
    localparam logic [3:0] S_MUL1  = 4'd7;
    localparam logic [3:0] S_DIV1  = 4'd8;
    localparam logic [3:0] S_UPD   = 4'd9;
    localparam logic [3:0] S_REN   = 4'd10;
    localparam logic [3:0] S_ENDC  = 4'd11;
    localparam logic [3:0] S_TERM0 = 4'd12;
    localparam logic [3:0] S_TERM1 = 4'd13;
    localparam logic [3:0] S_FIN   = 4'd14;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_stat.in_op == OP_LOAD) o_cmd.load_wr = 1'b1;
                    else n_state = S_BS;
                end
            end
            S_BS: begin
                if (!i_stat.bs_needed) begin
                    n_state = S_RD0;
                end else if (i_stat.push_ok) begin
                    o_cmd.push_bs = 1'b1;
                    n_state = S_RD0;
                end
            end
            S_RD0: n_state = S_RD1;
            S_RD1: begin
                o_cmd.lat_c0  = 1'b1;
                o_cmd.rd_next = 1'b1;
                n_state = S_RD2;
            end
            S_RD2: begin
                o_cmd.lat_c1 = 1'b1;
                n_state = S_MUL0;
            end
            S_MUL0: begin
                o_cmd.mul = 1'b1;
                n_cnt = '0;
                n_state = S_DIV0;
            end
            S_DIV0: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul     = 1'b1;
                o_cmd.mul_sel = 1'b1;
                n_cnt = '0;
                n_state = S_DIV1;
            end
            S_DIV1: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_cnt = '0;
                n_state = S_REN;
            end
            S_REN: begin
                if (r_cnt >= {1'b0, i_stat.b}) begin
                    n_state = S_ENDC;
                end else if (i_stat.emit_c) begin
                    if (i_stat.push_ok) begin
                        o_cmd.push_grp = 1'b1;
                        o_cmd.ren_emit = 1'b1;
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end else if (i_stat.str_c) begin
                    o_cmd.ren_str = 1'b1;
                    n_cnt = r_cnt + CNT_W'(1);
                end else begin
                    n_state = S_ENDC;
                end
            end
            S_ENDC: n_state = i_stat.end_blk ? S_TERM0 : S_FIN;
            S_TERM0: begin
                if (i_stat.push_ok) begin
                    o_cmd.push_grp   = 1'b1;
                    o_cmd.term_shift = 1'b1;
                    n_state = S_TERM1;
                end
            end
            S_TERM1: begin
                if (i_stat.lo_zero) begin
                    n_state = S_FIN;
                end else if (i_stat.push_ok) begin
                    o_cmd.push_grp = 1'b1;
                    o_cmd.grp_one  = 1'b1;
                    if (i_stat.lo_top) o_cmd.term_shift = 1'b1;
                    else n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!i_stat.hold_v) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.push_ok) begin
                    o_cmd.fin   = 1'b1;
                    o_cmd.flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

>>> rtl/core/aeb_dp.sv
// datapath of the blocked arithmetic encoder
// table memory, multiplier, serial divider, interval and result registers; uses aeb_pkg
module aeb_dp import aeb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  logic                 i_operation,
    input  logic [IDX_W-1:0]     i_index,
    input  logic [CUM_W-1:0]     i_cum_value,
    input  logic                 i_stream_last,
    input  logic                 i_cfg_wr,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CUM_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_kind,
    output logic                 o_lead_bit,
    output logic [WORD_W-1:0]    o_follow_count,
    output logic [WORD_W-1:0]    o_block_offset,
    output logic                 o_overflow,
    output logic                 o_last
);

    logic [CUM_W-1:0] r_mem [TAB_DEPTH];
    logic [CUM_W-1:0] r_rdata;

    logic [CUM_W-1:0]  r_total;
    logic [B_W-1:0]    r_b;
    logic [BLK_W-1:0]  r_bs, r_bp;
    logic [WORD_W-1:0] r_bitpos, r_pend;
    logic              r_ovf;
    logic [IV_W-1:0]   r_lo, r_hi;
    logic [IDX_W-1:0]  r_sym;
    logic              r_last;
    logic [CUM_W-1:0]  r_c0, r_c1;
    logic [PROD_W-1:0] r_prod;
    logic [CUM_W-1:0]  r_rem;
    logic [LEN_W-1:0]  r_q0;

    logic              r_hv, r_hkind, r_hlead, r_hovf;
    logic [WORD_W-1:0] r_hfollow, r_hoff;
    logic              r_ov;

    logic [IV_W-1:0]   mask, mid, qtr, lo_sh, hi_sh;
    logic [LEN_W-1:0]  len;
    logic [IDX_W-1:0]  raddr;
    logic [CUM_W-1:0]  rsat, t_new, csel;
    logic [B_W-1:0]    b_new;
    logic [CUM_W:0]    rem_sh;
    logic              lo_top, push_ok, nkind, nlead;
    logic [WORD_W-1:0] nfollow, noff;

    assign mask  = f_mask(r_b);
    assign mid   = IV_W'(1) << (r_b - B_W'(1));
    assign qtr   = IV_W'(1) << (r_b - B_W'(2));
    assign len   = {1'b0, (r_hi - r_lo) & mask} + LEN_W'(1);
    assign lo_sh = (r_lo << 1) & mask;
    assign hi_sh = ((r_hi << 1) | IV_W'(1)) & mask;
    assign lo_top = |(r_lo & mid);
    assign raddr = i_cmd.rd_next ? r_sym + IDX_W'(1) : r_sym;
    assign rsat  = (r_rdata > r_total) ? r_total : r_rdata;
    assign csel  = i_cmd.mul_sel ? r_c1 : r_c0;
    assign rem_sh = {r_rem, r_prod[PROD_W-1]};
    assign t_new = f_eff(i_cfg_data);
    assign b_new = f_width(t_new);
    assign push_ok = !r_hv || !r_ov || i_ready;

    assign nkind   = i_cmd.push_bs;
    assign nlead   = i_cmd.push_bs ? 1'b0 : (i_cmd.grp_one ? 1'b1 : lo_top);
    assign nfollow = i_cmd.push_bs ? '0 : r_pend;
    assign noff    = i_cmd.push_bs ? r_bitpos : '0;

    always_comb begin
        o_stat.in_op     = i_operation;
        o_stat.bs_needed = (r_bs != '0) && (r_bp == '0);
        o_stat.emit_c    = (r_lo >= mid) || (r_hi < mid);
        o_stat.str_c     = (r_lo >= qtr) && ({1'b0, r_hi} < ({1'b0, mid} + {1'b0, qtr}));
        o_stat.end_blk   = r_last ||
                           ((r_bs != '0) && (({1'b0, r_bp} + 17'd1) >= {1'b0, r_bs}));
        o_stat.lo_zero   = (r_lo == '0);
        o_stat.lo_top    = lo_top;
        o_stat.push_ok   = push_ok;
        o_stat.hold_v    = r_hv;
        o_stat.b         = r_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && (i_index <= IDX_W'(NUM_SYMBOLS))) begin
            r_mem[i_index] <= i_cum_value;
        end
        r_rdata <= r_mem[raddr];
    end

    // arithmetic payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sym  <= (i_index >= IDX_W'(NUM_SYMBOLS)) ? IDX_W'(NUM_SYMBOLS - 1) : i_index;
            r_last <= i_stream_last;
        end
        if (i_cmd.lat_c0) r_c0 <= rsat;
        if (i_cmd.lat_c1) r_c1 <= rsat;
        if (i_cmd.mul) begin
            r_prod <= len * csel;
            r_rem  <= '0;
            if (i_cmd.mul_sel) r_q0 <= r_prod[LEN_W-1:0];
        end
        if (i_cmd.div_step) begin
            if (rem_sh >= {1'b0, r_total}) begin
                r_rem  <= CUM_W'(rem_sh - {1'b0, r_total});
                r_prod <= {r_prod[PROD_W-2:0], 1'b1};
            end else begin
                r_rem  <= CUM_W'(rem_sh);
                r_prod <= {r_prod[PROD_W-2:0], 1'b0};
            end
        end
        if (i_cmd.push_bs || i_cmd.push_grp) begin
            r_hkind   <= nkind;
            r_hlead   <= nlead;
            r_hfollow <= nfollow;
            r_hoff    <= noff;
            r_hovf    <= r_ovf;
            if (r_hv) begin
                o_kind         <= r_hkind;
                o_lead_bit     <= r_hlead;
                o_follow_count <= r_hfollow;
                o_block_offset <= r_hoff;
                o_overflow     <= r_hovf;
                o_last         <= 1'b0;
            end
        end
        if (i_cmd.flush) begin
            o_kind         <= r_hkind;
            o_lead_bit     <= r_hlead;
            o_follow_count <= r_hfollow;
            o_block_offset <= r_hoff;
            o_overflow     <= r_hovf;
            o_last         <= 1'b1;
        end
    end

    // coder state and result control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= CUM_W'(1);
            r_b      <= B_W'(2);
            r_bs     <= '0;
            r_bp     <= '0;
            r_bitpos <= '0;
            r_pend   <= '0;
            r_ovf    <= 1'b0;
            r_lo     <= '0;
            r_hi     <= IV_W'(3);
            r_hv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            if (i_cfg_wr) begin
                unique case (i_cfg_index)
                    REG_TOTAL: begin
                        r_total <= t_new;
                        r_b     <= b_new;
                        r_lo    <= '0;
                        r_hi    <= f_mask(b_new);
                    end
                    REG_BLOCK: r_bs <= i_cfg_data[BLK_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.upd) begin
                r_lo <= (r_lo + r_q0[IV_W-1:0]) & mask;
                r_hi <= (r_lo + r_prod[IV_W-1:0] - IV_W'(1)) & mask;
            end
            if (i_cmd.ren_emit) begin
                r_lo <= lo_sh;
                r_hi <= hi_sh;
            end
            if (i_cmd.ren_str) begin
                r_lo <= lo_sh ^ mid;
                r_hi <= hi_sh ^ mid;
                if (r_pend == '1) r_ovf <= 1'b1;
                else r_pend <= r_pend + WORD_W'(1);
            end
            if (i_cmd.term_shift) r_lo <= lo_sh;
            if (i_cmd.push_grp) begin
                r_pend   <= '0;
                r_bitpos <= r_bitpos + WORD_W'(1) + r_pend;
            end
            if (i_cmd.push_bs || i_cmd.push_grp) begin
                r_hv <= 1'b1;
                if (r_hv) r_ov <= 1'b1;
            end
            if (i_cmd.flush) begin
                r_hv <= 1'b0;
                r_ov <= 1'b1;
            end
            if (i_cmd.fin) begin
                if (o_stat.end_blk) begin
                    r_lo <= '0;
                    r_hi <= mask;
                    r_bp <= '0;
                    if (r_last) r_bitpos <= '0;
                end else if (r_bs != '0) begin
                    r_bp <= r_bp + BLK_W'(1);
                end else begin
                    r_bp <= '0;
                end
            end
        end
    end

    assign o_valid = r_ov;

endmodule

>>> rtl/core/arithmetic_encoder_blocked_top.sv
// top level of the blocked arithmetic encoder: controller and datapath
// a load item writes the table from idle; an encode item runs two 52-step serial
// divisions plus renormalization shifts and termination bits, with o_ready low
// results leave through a one-deep hold and an output register, last result on flush
// synchronous active-low reset: interval [0,3], total 1, no blocking, no table clear
module arithmetic_encoder_blocked_top import aeb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_operation,
    input  logic [IDX_W-1:0]     i_index,
    input  logic [CUM_W-1:0]     i_cum_value,
    input  logic                 i_stream_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CUM_W-1:0]     i_cfg_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_kind,
    output logic                 o_lead_bit,
    output logic [WORD_W-1:0]    o_follow_count,
    output logic [WORD_W-1:0]    o_block_offset,
    output logic                 o_overflow,
    output logic                 o_last
);

    t_cmd  cmd;
    t_stat stat;

    // register writes only while the controller is idle
    assign o_cfg_ready = o_ready;

    aeb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    aeb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_operation    (i_operation),
        .i_index        (i_index),
        .i_cum_value    (i_cum_value),
        .i_stream_last  (i_stream_last),
        .i_cfg_wr       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_lead_bit     (o_lead_bit),
        .o_follow_count (o_follow_count),
        .o_block_offset (o_block_offset),
        .o_overflow     (o_overflow),
        .o_last         (o_last)
    );

endmodule
